// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, codes and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W  = 32;

  localparam logic [7:0]       ALL_ONES_BYTE = 8'hFF;
  localparam logic [MAC_W-1:0] BCAST_MAC     = {6{ALL_ONES_BYTE}};
  localparam logic [IP_W-1:0]  BCAST_IP      = {4{ALL_ONES_BYTE}};

  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_RX     = 2'd1,
    FUNC_SEND   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TX     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TXOP_NONE    = 2'd0,
    TXOP_REQUEST = 2'd1,
    TXOP_REPLY   = 2'd2
  } txop_e;

  typedef enum logic {
    CFG_OWN_MAC = 1'b0,
    CFG_OWN_IP  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  // last field in the lowest bits
  typedef struct packed {
    logic [MAC_W-1:0] req_target_mac;
    logic [IP_W-1:0]  query_ip;
    logic [IP_W-1:0]  rx_target_ip;
    logic [IP_W-1:0]  rx_sender_ip;
    logic [MAC_W-1:0] rx_sender_mac;
    logic [15:0]      rx_opcode;
  } in_data_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic             table_full;
    logic [IP_W-1:0]  tx_target_ip;
    logic [MAC_W-1:0] tx_target_mac;
    logic [1:0]       tx_opcode;
    logic [MAC_W-1:0] frame_dest_mac;
    logic [MAC_W-1:0] found_mac;
    logic             lookup_hit;
  } out_data_t;

  localparam int unsigned IN_DATA_W  = $bits(in_data_t);
  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic hit;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences one request: capture, table scan for lookups, result hand-off.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  arpc_pkg::dp_status_t   status_i,
  output arpc_pkg::ctrl_cmd_t    cmd_o
);
  import arpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!status_i.is_lookup || status_i.hit || status_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.accept    = s_axis_tvalid_i;
      end
      ST_SEARCH: begin
        cmd_o.scan = status_i.is_lookup;
      end
      ST_RESULT: begin
        cmd_o.load = status_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_search_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan |-> (state_q == ST_SEARCH) && status_i.is_lookup)
    else $error("scan outside a lookup");
`endif

endmodule

// ===== sv/arpc_dp.sv =====
// ----------------------------------------------------------------------------
// ARP cache datapath
// Config registers, item capture, table memory with scan, output register.
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int unsigned TABLE_DEPTH = arpc_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_index_i,
  input  logic [arpc_pkg::MAC_W-1:0]       cfg_data_i,
  input  logic [arpc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [1:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [arpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,
  input  arpc_pkg::ctrl_cmd_t              cmd_i,
  output arpc_pkg::dp_status_t             status_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // configuration
  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OWN_MAC: own_mac_q <= cfg_data_i;
        CFG_OWN_IP:  own_ip_q  <= cfg_data_i[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  in_data_t item_q;
  logic [1:0] func_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_t'(s_axis_tdata_i);
      func_q <= s_axis_tuser_i;
    end
  end

  // table; entry zero is the fixed broadcast pair and is never written
  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rd_q;
  logic             rd_zero_q;
  logic             rd_vld_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] scan_idx_q;
  logic             hit_q;
  logic [MAC_W-1:0] found_mac_q;

  logic [IP_W-1:0]  eff_ip;
  logic [MAC_W-1:0] eff_mac;
  logic             match;
  logic             issue;
  logic             own_target;
  logic             room;
  logic             append;

  assign eff_ip  = rd_zero_q ? BCAST_IP : rd_q.ip;
  assign eff_mac = rd_zero_q ? BCAST_MAC : rd_q.mac;
  assign match   = rd_vld_q && (eff_ip == item_q.query_ip);
  assign issue   = cmd_i.scan && (scan_idx_q < cnt_q) && !match;

  assign own_target = (item_q.rx_target_ip == own_ip_q);
  assign room       = (cnt_q < CNT_W'(TABLE_DEPTH));
  assign append     = cmd_i.load && (func_q == FUNC_RX) && own_target && room;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q      <= mem_q[scan_idx_q[IDX_W-1:0]];
      rd_zero_q <= (scan_idx_q == '0);
    end
    if (append) begin
      mem_q[cnt_q[IDX_W-1:0]] <= '{mac: item_q.rx_sender_mac, ip: item_q.rx_sender_ip};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (append) cnt_d = cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      found_mac_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= issue;
      if (cmd_i.accept) begin
        scan_idx_q  <= '0;
        hit_q       <= 1'b0;
        found_mac_q <= '0;
      end else begin
        if (issue) scan_idx_q <= scan_idx_q + CNT_W'(1);
        if (cmd_i.scan && match) begin
          hit_q       <= 1'b1;
          found_mac_q <= eff_mac;
        end
      end
    end
  end

  // result
  out_data_t res;
  kind_e     res_kind;

  always_comb begin
    res      = '0;
    res_kind = KIND_NONE;
    case (func_q)
      FUNC_LOOKUP: begin
        res_kind       = KIND_LOOKUP;
        res.lookup_hit = hit_q;
        res.found_mac  = found_mac_q;
      end
      FUNC_RX: begin
        if (own_target) begin
          if (item_q.rx_opcode == ARP_OP_REQUEST) begin
            res_kind           = KIND_TX;
            res.frame_dest_mac = item_q.rx_sender_mac;
            res.tx_opcode      = TXOP_REPLY;
            res.tx_target_mac  = item_q.rx_sender_mac;
            res.tx_target_ip   = item_q.rx_sender_ip;
          end
          res.table_full = !room;
        end
      end
      FUNC_SEND: begin
        res_kind           = KIND_TX;
        res.frame_dest_mac = BCAST_MAC;
        res.tx_opcode      = TXOP_REQUEST;
        res.tx_target_mac  = item_q.req_target_mac;
        res.tx_target_ip   = item_q.query_ip;
      end
      default: ;
    endcase
  end

  // output register
  logic      m_vld_q;
  out_data_t m_data_q;
  logic [1:0] m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_data_q <= res;
      m_user_q <= res_kind;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  assign status_o.is_lookup = (func_q == FUNC_LOOKUP);
  assign status_o.hit       = match;
  assign status_o.scan_done = (scan_idx_q >= cnt_q) && !rd_vld_q;
  assign status_o.out_free  = !m_vld_q || m_axis_tready_i;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!m_vld_q || m_axis_tready_i))
    else $error("pending result overwritten");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (scan_idx_q < cnt_q) && (scan_idx_q < CNT_W'(TABLE_DEPTH)))
    else $error("scan read beyond filled entries");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    append |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not advance entry count");
`endif

endmodule

// ===== sv/arp_cache_responder.sv =====
// ----------------------------------------------------------------------------
// ARP cache and responder
// IPv4-to-MAC cache with ARP reply and request generation.
// ----------------------------------------------------------------------------
// Each request yields exactly one result on the master side. The block holds
// one request at a time. A lookup scans the table from the oldest entry, one
// entry per cycle through the single table read port, and stops at the first
// match, or ends after the last filled entry on a miss. Received packets, send
// commands and the unused func code need no table scan. The request side is
// ready again in the cycle after the result register has been loaded. A result
// that is not taken holds the next request back in the result state. Entry
// zero is the broadcast pair and is built in, so no clearing pass follows
// reset. When the table is full, a learned pair is dropped and table_full is
// set in the result.
module arp_cache_responder #(
  parameter int unsigned TABLE_DEPTH = arpc_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [arpc_pkg::MAC_W-1:0]       cfg_data_i,
  // request stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // rx_opcode, rx_sender_mac, rx_sender_ip, rx_target_ip, query_ip,
  // req_target_mac
  input  logic [arpc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // func
  input  logic [1:0]                       s_axis_tuser_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // lookup_hit, found_mac, frame_dest_mac, tx_opcode, tx_target_mac,
  // tx_target_ip, table_full, zero pad
  output logic [arpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // kind
  output logic [1:0]                       m_axis_tuser_o
);
  import arpc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  arpc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
